// File: hw/rtl/mwpo_pkg.sv
`default_nettype none

package mwpo_pkg;

   // Waveform selection codes held in the shape register.
   typedef enum logic [1:0] {
      SHAPE_SINE     = 2'd0,
      SHAPE_SQUARE   = 2'd1,
      SHAPE_TRIANGLE = 2'd2,
      SHAPE_SAWTOOTH = 2'd3
   } wave_shape_type;

   // Width of the phase slice that shapes the waveform.
   localparam int unsigned TOP_BITS = 16;

   // Width of the sample magnitude stored in the quarter-wave table.
   localparam int unsigned MAG_BITS = 15;

   // Width of the offset within one quadrant.
   localparam int unsigned QUAD_BITS = 14;

   // Pi/2 in Q30.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Taylor series denominators (2n)(2n+1) for n = 1 .. 8.
   localparam longint unsigned TAYLOR_DIV [1:8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   // Per-request control carried from the phase stage to the output stage.
   typedef struct packed {
      wave_shape_type       shape;
      logic [TOP_BITS-1:0]  top;
      logic                 negate;
      logic                 wrapped;
   } stage_type;

endpackage

`default_nettype wire

// File: hw/rtl/mwpo_sine_rom.sv
`default_nettype none

module mwpo_sine_rom #(
   parameter int unsigned SINE_TABLE_DEPTH = 256,
   parameter int unsigned ADDR_W           = 9
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [mwpo_pkg::MAG_BITS-1:0] rd_data
);

   typedef logic [mwpo_pkg::MAG_BITS-1:0] entry_array_type [0:SINE_TABLE_DEPTH];

   // One quarter-wave entry: Taylor series in Q30 with truncating steps,
   // rounded half up to Q15 and clipped to the largest positive code.
   function automatic logic [mwpo_pkg::MAG_BITS-1:0] sine_entry(input longint unsigned i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned term;
      longint unsigned q15;
      x    = (mwpo_pkg::HALF_PI_Q30 * i) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      pos  = x;
      neg  = 64'd0;
      term = x;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / mwpo_pkg::TAYLOR_DIV[n];
         if (n % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      q15 = ((pos - neg) + 64'd16384) >> 15;
      if (q15 > 64'd32767) begin
         q15 = 64'd32767;
      end
      return q15[mwpo_pkg::MAG_BITS-1:0];
   endfunction

   function automatic entry_array_type build_table();
      entry_array_type tbl;
      for (int i = 0; i <= int'(SINE_TABLE_DEPTH); i++) begin
         tbl[i] = sine_entry(longint'(i));
      end
      return tbl;
   endfunction

   localparam entry_array_type SINE_TABLE = build_table();

   logic [mwpo_pkg::MAG_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_TABLE[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mwpo_shaper.sv
`default_nettype none

module mwpo_shaper (
   input  wire mwpo_pkg::stage_type                 stage,
   input  wire logic        [mwpo_pkg::MAG_BITS-1:0] sine_mag,
   output logic signed      [15:0]                   sample
);

   logic signed [17:0] tri_wide;
   logic signed [15:0] tri_sat;
   logic signed [16:0] sine_wide;

   // Triangle rises over the first half cycle and falls over the second.
   // Only the peak at exactly one half cycle reaches +1.0 and is clipped.
   always_comb begin
      if (stage.top[15]) begin
         tri_wide = 18'sd98304 - $signed({1'b0, stage.top, 1'b0});
      end else begin
         tri_wide = $signed({1'b0, stage.top, 1'b0}) - 18'sd32768;
      end
      if (tri_wide > 18'sd32767) begin
         tri_sat = 16'sd32767;
      end else begin
         tri_sat = tri_wide[15:0];
      end
   end

   assign sine_wide = stage.negate ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});

   always_comb begin
      case (stage.shape)
         mwpo_pkg::SHAPE_SINE: begin
            sample = sine_wide[15:0];
         end
         mwpo_pkg::SHAPE_SQUARE: begin
            sample = stage.top[15] ? -16'sd32768 : 16'sd32767;
         end
         mwpo_pkg::SHAPE_TRIANGLE: begin
            sample = tri_sat;
         end
         mwpo_pkg::SHAPE_SAWTOOTH: begin
            sample = $signed({~stage.top[15], stage.top[14:0]});
         end
         default: begin
            sample = 16'sd0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/multi_waveform_phase_oscillator.sv
`default_nettype none

// Direct digital synthesis oscillator. Each request is one sample tick that
// carries a phase step (a fraction of one waveform cycle times 2^32). The
// block answers with one Q1.15 sample of the selected waveform, taken from
// the phase before the step, and a flag that is set when the step carried the
// phase accumulator past the end of a cycle. The waveform (sine, square,
// triangle, sawtooth) is chosen by the two-bit shape register, which should
// only be written while no request is in flight. The block takes one request
// per clock while req_stall is low: the phase add and table address are
// formed in the first stage, the quarter-wave table is read into a register
// there, and the waveform is finished into the response register in the
// second, where the response is held until it is taken. A stalled response
// backs up the two stages before the request side is stalled.

module multi_waveform_phase_oscillator #(
   parameter int unsigned SINE_TABLE_DEPTH = 256,
   parameter int unsigned PHASE_BITS       = 32
) (
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  logic               csr_write_en,
   input  wire  logic [1:0]         csr_write_data,
   input  wire  logic               req_valid,
   output logic                     req_stall,
   input  wire  logic [30:0]        req_phase_step,
   output logic                     rsp_valid,
   input  wire  logic               rsp_stall,
   output logic signed [15:0]       rsp_wave_sample,
   output logic                     rsp_cycle_wrapped
);

   localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned PROD_W = mwpo_pkg::QUAD_BITS + ADDR_W;
   localparam int unsigned TOP_BITS = mwpo_pkg::TOP_BITS;

   // Control state.
   logic [PHASE_BITS-1:0]           phase_acc_ff;
   logic [PHASE_BITS-1:0]           phase_acc_in;
   mwpo_pkg::wave_shape_type        shape_ff;
   logic                            s1_valid_ff;
   logic                            rsp_valid_ff;

   // Payload registers.
   mwpo_pkg::stage_type             s1_ff;
   mwpo_pkg::stage_type             s1_in;
   logic signed [15:0]              sample_ff;
   logic                            wrapped_ff;

   // Handshake.
   logic                            out_free;
   logic                            s1_move;
   logic                            s1_free;
   logic                            accept;

   // Phase and table address.
   logic [PHASE_BITS-2:0]           step_aligned;
   logic [PHASE_BITS:0]             phase_sum;
   logic [TOP_BITS-1:0]             top;
   logic [mwpo_pkg::QUAD_BITS-1:0]  quad_off;
   logic [PROD_W-1:0]               quad_prod;
   logic [ADDR_W-1:0]               quad_k;
   logic [ADDR_W-1:0]               rom_addr;
   logic [mwpo_pkg::MAG_BITS-1:0]   sine_mag;
   logic signed [15:0]              sample_in;

   // The second stage may move when the response register is empty or is
   // being taken; the first stage may load when it is empty or moving on.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // Align the 31-bit step fraction to the accumulator width.
   generate
      if (PHASE_BITS >= 32) begin : g_step_up
         assign step_aligned = (PHASE_BITS - 1)'(req_phase_step) << (PHASE_BITS - 32);
      end else begin : g_step_dn
         assign step_aligned = req_phase_step[30 -: (PHASE_BITS - 1)];
      end
   endgenerate

   assign phase_sum    = {1'b0, phase_acc_ff} + {2'b00, step_aligned};
   assign phase_acc_in = phase_sum[PHASE_BITS-1:0];

   // Quadrant and table index from the top bits of the current phase. Odd
   // quadrants read the table backward, the second half cycle is negated.
   assign top       = phase_acc_ff[PHASE_BITS-1 -: TOP_BITS];
   assign quad_off  = top[mwpo_pkg::QUAD_BITS-1:0];
   assign quad_prod = PROD_W'(quad_off) * PROD_W'(SINE_TABLE_DEPTH);
   assign quad_k    = quad_prod[mwpo_pkg::QUAD_BITS +: ADDR_W];
   assign rom_addr  = top[TOP_BITS-2] ? (ADDR_W'(SINE_TABLE_DEPTH) - quad_k) : quad_k;

   always_comb begin
      s1_in.shape   = shape_ff;
      s1_in.top     = top;
      s1_in.negate  = top[TOP_BITS-1];
      s1_in.wrapped = phase_sum[PHASE_BITS];
   end

   mwpo_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .ADDR_W           (ADDR_W)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rom_addr),
      .rd_data (sine_mag)
   );

   mwpo_shaper u_shaper (
      .stage    (s1_ff),
      .sine_mag (sine_mag),
      .sample   (sample_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         shape_ff     <= mwpo_pkg::SHAPE_SINE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            shape_ff <= mwpo_pkg::wave_shape_type'(csr_write_data);
         end
         if (accept) begin
            phase_acc_ff <= phase_acc_in;
         end
         if (s1_free) begin
            s1_valid_ff <= accept;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         sample_ff  <= sample_in;
         wrapped_ff <= s1_ff.wrapped;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wave_sample   = sample_ff;
   assign rsp_cycle_wrapped = wrapped_ff;

endmodule

`default_nettype wire

// File: verif/multi_waveform_phase_oscillator_test.sv
`default_nettype none

module multi_waveform_phase_oscillator_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_DEPTH     = 256;
   localparam int unsigned ACC_BITS        = 32;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 66;
   localparam int unsigned DRAIN_CYCLES    = 8;

   // Pi/2 in Q30. The sine table is rebuilt from it with the same truncating
   // Taylor series that the hardware table is specified with.
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

   // One response as the bench expects it.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               wrapped;
   } osc_out_type;

   // One row of the directed table. When pinned is set, the response fields
   // are typed in here and replace the model's prediction for that request.
   typedef struct packed {
      mwpo_pkg::wave_shape_type shape;
      logic [30:0]              step;
      logic                     pinned;
      logic signed [15:0]       sample;
      logic                     wrapped;
   } tone_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [30:0]        req_phase_step = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_wave_sample;
   logic               rsp_cycle_wrapped;

   // Typed-in expectation that travels alongside the request payload, so the
   // scoreboard picks it up at the very edge where the request is accepted.
   logic               pin_known = 1'b0;
   logic signed [15:0] pin_sample = '0;
   logic               pin_wrapped = 1'b0;

   // Model state: quarter-wave table, phase accumulator and shape register.
   int                         quarter_sine [0:TABLE_DEPTH];
   logic [ACC_BITS-1:0]        model_phase;
   mwpo_pkg::wave_shape_type   model_shape;
   logic [ACC_BITS:0]          phase_sum;
   osc_out_type                predicted;
   osc_out_type                oldest;
   osc_out_type                awaited_samples [$];

   int unsigned           fail_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           stall_left = 0;
   int unsigned           stall_pick;
   // While calm is set, neither side idles, so back-to-back traffic is covered.
   bit                    calm = 1'b0;

   multi_waveform_phase_oscillator #(
      .SINE_TABLE_DEPTH (TABLE_DEPTH),
      .PHASE_BITS       (ACC_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_phase_step    (req_phase_step),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wave_sample   (rsp_wave_sample),
      .rsp_cycle_wrapped (rsp_cycle_wrapped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed table. The accumulator starts at zero after reset and every
   // comment gives the phase before the step. Rows whose sine value is not
   // obvious are left to the model.
   tone_row_type tone_rows [24] = '{
      // Sine: zero crossings, the positive peak, and the wrap at the end.
      '{mwpo_pkg::SHAPE_SINE,     31'h4000_0000, 1'b1, 16'sd0,      1'b0}, // phase 0
      '{mwpo_pkg::SHAPE_SINE,     31'h4000_0000, 1'b0, 16'sd0,      1'b0}, // quarter, peak
      '{mwpo_pkg::SHAPE_SINE,     31'h7FFF_FFFF, 1'b1, 16'sd0,      1'b0}, // half, zero
      '{mwpo_pkg::SHAPE_SINE,     31'h0000_0001, 1'b0, 16'sd0,      1'b0}, // last step, wraps
      '{mwpo_pkg::SHAPE_SINE,     31'h2AAA_AAAA, 1'b1, 16'sd0,      1'b0}, // phase 0 again
      '{mwpo_pkg::SHAPE_SINE,     31'h5555_5555, 1'b0, 16'sd0,      1'b0},
      '{mwpo_pkg::SHAPE_SINE,     31'h0000_0001, 1'b0, 16'sd0,      1'b0}, // top of quadrant 1
      '{mwpo_pkg::SHAPE_SINE,     31'h4000_0000, 1'b1, 16'sd0,      1'b0}, // half, zero
      '{mwpo_pkg::SHAPE_SINE,     31'h4000_0000, 1'b0, 16'sd0,      1'b0}, // trough, wraps
      // Square: both sides of the half-cycle switch point.
      '{mwpo_pkg::SHAPE_SQUARE,   31'h0000_0000, 1'b1, 16'sd32767,  1'b0}, // zero step
      '{mwpo_pkg::SHAPE_SQUARE,   31'h7FFF_FFFF, 1'b1, 16'sd32767,  1'b0},
      '{mwpo_pkg::SHAPE_SQUARE,   31'h0000_0001, 1'b1, 16'sd32767,  1'b0}, // just below half
      '{mwpo_pkg::SHAPE_SQUARE,   31'h0000_0000, 1'b1, 16'sh8000,   1'b0}, // exactly half
      '{mwpo_pkg::SHAPE_SQUARE,   31'h7FFF_FFFF, 1'b1, 16'sh8000,   1'b0},
      '{mwpo_pkg::SHAPE_SQUARE,   31'h0000_0001, 1'b1, 16'sh8000,   1'b1}, // wraps to zero
      // Triangle: bottom, mid rise, top of the rise, the +1.0 saturation.
      '{mwpo_pkg::SHAPE_TRIANGLE, 31'h4000_0000, 1'b1, 16'sh8000,   1'b0},
      '{mwpo_pkg::SHAPE_TRIANGLE, 31'h3FFF_FFFF, 1'b1, 16'sd0,      1'b0},
      '{mwpo_pkg::SHAPE_TRIANGLE, 31'h0000_0001, 1'b1, 16'sd32766,  1'b0},
      '{mwpo_pkg::SHAPE_TRIANGLE, 31'h7FFF_FFFF, 1'b1, 16'sd32767,  1'b0}, // +1.0 clips
      '{mwpo_pkg::SHAPE_TRIANGLE, 31'h2AAA_AAAA, 1'b1, -16'sd32766, 1'b1},
      // Sawtooth: the ramp across half, its top and bottom.
      '{mwpo_pkg::SHAPE_SAWTOOTH, 31'h5555_5557, 1'b0, 16'sd0,      1'b0},
      '{mwpo_pkg::SHAPE_SAWTOOTH, 31'h7FFF_FFFF, 1'b1, 16'sd0,      1'b0}, // half
      '{mwpo_pkg::SHAPE_SAWTOOTH, 31'h0000_0001, 1'b1, 16'sd32767,  1'b1}, // ramp top, wraps
      '{mwpo_pkg::SHAPE_SAWTOOTH, 31'h0000_0000, 1'b1, 16'sh8000,   1'b0}  // ramp bottom
   };

   // One entry of the quarter-wave table: Taylor series of sin(x) to x^17
   // in Q30 with truncation at every product and division, then rounded
   // half up into Q15 and clipped at +1.0.
   function automatic int sine_entry(input int unsigned i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned term;
      longint unsigned q15;
      longint unsigned n;
      x = (QUARTER_TURN_Q30 * i) / TABLE_DEPTH;
      x2 = (x * x) >> 30;
      pos = x;
      neg = 0;
      term = x;
      for (n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n[0]) begin
            neg += term;
         end else begin
            pos += term;
         end
      end
      q15 = ((pos - neg) + (64'd1 << 14)) >> 15;
      if (q15 > 64'd32767) begin
         q15 = 64'd32767;
      end
      return int'(q15);
   endfunction

   // Waveform value of a given phase. Only the top 16 phase bits matter.
   function automatic logic signed [15:0] shape_value(input logic [ACC_BITS-1:0] phase,
                                                      input mwpo_pkg::wave_shape_type shape);
      logic [15:0] t;
      int unsigned k;
      int unsigned idx;
      int          v;
      t = phase[ACC_BITS-1 -: 16];
      case (shape)
         mwpo_pkg::SHAPE_SINE: begin
            // Odd quadrants read the table backward, the second half cycle negates.
            k = (32'(t[13:0]) * TABLE_DEPTH) >> 14;
            idx = t[14] ? TABLE_DEPTH - k : k;
            v = t[15] ? -quarter_sine[idx] : quarter_sine[idx];
         end
         mwpo_pkg::SHAPE_SQUARE: begin
            v = t[15] ? -32768 : 32767;
         end
         mwpo_pkg::SHAPE_TRIANGLE: begin
            v = t[15] ? 98304 - 2 * int'(t) : 2 * int'(t) - 32768;
            if (v > 32767) begin
               v = 32767;
            end
         end
         default: begin
            v = int'(t) - 32768;
         end
      endcase
      return 16'(v);
   endfunction

   // The 31-bit step is a fraction of a cycle times 2^32; line it up with
   // the accumulator width.
   function automatic logic [ACC_BITS-1:0] aligned_step(input logic [30:0] step);
      if (ACC_BITS >= 32) begin
         return ACC_BITS'(64'(step) << (ACC_BITS - 32));
      end else begin
         return ACC_BITS'(64'(step) >> (32 - ACC_BITS));
      end
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      fail_count++;
      $error("%s: expected %0d, actual %0d", field, want, got);
   endtask

   // Scoreboard. Everything is sampled at the rising edge, before the
   // design's own updates for that edge land, so the order of processes
   // within the time step does not matter. The model advances on each
   // accepted request and the oldest expectation is compared with each
   // accepted response.
   always @(posedge clock) begin
      if (reset) begin
         model_phase = '0;
         model_shape = mwpo_pkg::SHAPE_SINE;
         awaited_samples.delete();
      end else begin
         if (csr_write_en) begin
            model_shape = mwpo_pkg::wave_shape_type'(csr_write_data);
         end
         if (req_valid && !req_stall) begin
            // The sample comes from the phase before the step is added.
            predicted.sample = shape_value(model_phase, model_shape);
            phase_sum = {1'b0, model_phase} + {1'b0, aligned_step(req_phase_step)};
            predicted.wrapped = phase_sum[ACC_BITS];
            model_phase = phase_sum[ACC_BITS-1:0];
            if (pin_known) begin
               predicted.sample = pin_sample;
               predicted.wrapped = pin_wrapped;
            end
            awaited_samples.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_samples.size() == 0) begin
               fail_count++;
               $error("response with no request outstanding: sample %0d, wrapped %0d",
                      rsp_wave_sample, rsp_cycle_wrapped);
            end else begin
               oldest = awaited_samples.pop_front();
               if (rsp_wave_sample !== oldest.sample) begin
                  note_mismatch("wave_sample", $signed(oldest.sample), rsp_wave_sample);
               end
               if (rsp_cycle_wrapped !== oldest.wrapped) begin
                  note_mismatch("cycle_wrapped", int'(oldest.wrapped),
                                int'(rsp_cycle_wrapped));
               end
            end
         end
      end
   end

   // Response back-pressure: mostly free-running, with short stall bursts
   // and the occasional long one. Calm phases run without any stall.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            stall_left = (stall_pick < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         end
      end
   end

   // Watchdog. A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Idle cycles before a request: usually none or a few, now and then many.
   function automatic int unsigned gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end else if (pick < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Random phase step. Small steps sweep the sine table slowly, audio-rate
   // tones at 48 kHz give realistic streams, and the rest pushes at the
   // edges of the field: tiny, huge, single bits and fully random words.
   function automatic logic [30:0] random_step();
      int unsigned     pick;
      longint unsigned tone_hz;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         return 31'($urandom_range(1, 1 << 20));
      end else if (pick < 55) begin
         return 31'($urandom);
      end else if (pick < 65) begin
         return 31'h7FFF_FFFF - 31'($urandom_range(0, 255));
      end else if (pick < 72) begin
         return 31'($urandom_range(0, 3));
      end else if (pick < 80) begin
         return 31'd1 << $urandom_range(0, 30);
      end
      tone_hz = $urandom_range(20, 20000);
      return 31'((tone_hz << 32) / 48000);
   endfunction

   // Present one request and hold it until the design takes it. The payload
   // and any pinned expectation stay stable while the request is stalled.
   task automatic send_tick(input logic [30:0] step, input logic pinned,
                            input logic signed [15:0] sample, input logic wrapped);
      repeat (gap_length()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_phase_step <= step;
      pin_known <= pinned;
      pin_sample <= sample;
      pin_wrapped <= wrapped;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Every request produces exactly one response, so the design is idle
   // once the scoreboard holds no expectation.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The shape register may only change with nothing in flight.
   task automatic write_shape(input mwpo_pkg::wave_shape_type shape);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_write_data <= shape;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      mwpo_pkg::wave_shape_type current_shape;
      logic [1:0]               shape_sel;
      int unsigned              phase_idx;
      int unsigned              item;
      for (int unsigned i = 0; i <= TABLE_DEPTH; i++) begin
         quarter_sine[i] = sine_entry(i);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The shape register comes out of reset as sine; it is
      // rewritten whenever the table moves on to another shape.
      current_shape = mwpo_pkg::SHAPE_SINE;
      foreach (tone_rows[row]) begin
         if (tone_rows[row].shape != current_shape) begin
            current_shape = tone_rows[row].shape;
            write_shape(current_shape);
         end
         send_tick(tone_rows[row].step, tone_rows[row].pinned,
                   tone_rows[row].sample, tone_rows[row].wrapped);
      end

      // Random part in phases. The first four phases visit every shape in
      // order, the rest pick at random; every third phase runs with neither
      // side idling.
      for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         shape_sel = (phase_idx < 4) ? phase_idx[1:0] : 2'($urandom_range(0, 3));
         write_shape(mwpo_pkg::wave_shape_type'(shape_sel));
         calm = (phase_idx % 3 == 2);
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            send_tick(random_step(), 1'b0, 16'sd0, 1'b0);
         end
      end
      calm = 1'b0;

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && awaited_samples.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/mwpo_pkg.sv
hw/rtl/mwpo_sine_rom.sv
hw/rtl/mwpo_shaper.sv
hw/rtl/multi_waveform_phase_oscillator.sv
verif/multi_waveform_phase_oscillator_test.sv
